// ===== rtl/ccd_pkg.sv =====
// Shared types, constants and result builders for the camera container deframer.
package ccd_pkg;

    // Frame tags, little-endian words of four ASCII characters
    localparam logic [31:0] TAG_START    = 32'h5356_5848;
    localparam logic [31:0] TAG_VIDEO    = 32'h4656_5848;
    localparam logic [31:0] TAG_AUDIO    = 32'h4641_5848;
    localparam logic [31:0] TAG_INDEX    = 32'h4946_5848;
    localparam logic [31:0] AUDIO_PREFIX = 32'h0050_0100;
    localparam logic [31:0] START_SKIP   = 32'd12;
    localparam logic [31:0] INDEX_EXTRA  = 32'd8;
    localparam logic [31:0] PREFIX_LEN   = 32'd4;
    localparam logic [15:0] AUDIO_STEP_RESET = 16'd20;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_TAG    = 2'd1,
        ERR_PREFIX = 2'd2,
        ERR_SHORT  = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic        stream_id;
        logic [31:0] packet_time;
        logic [31:0] payload_len;
        logic [7:0]  data_byte;
        logic        last;
        err_t        error_code;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t rec;
    } push_t;

    function automatic result_t make_header(logic sid, logic [31:0] ptime, logic [31:0] len);
        result_t r;
        r.kind        = KIND_HEADER;
        r.stream_id   = sid;
        r.packet_time = ptime;
        r.payload_len = len;
        r.data_byte   = 8'd0;
        r.last        = (len == 32'd0);
        r.error_code  = ERR_NONE;
        return r;
    endfunction

    function automatic result_t make_payload(logic sid, logic [7:0] data, logic lst);
        result_t r;
        r.kind        = KIND_PAYLOAD;
        r.stream_id   = sid;
        r.packet_time = 32'd0;
        r.payload_len = 32'd0;
        r.data_byte   = data;
        r.last        = lst;
        r.error_code  = ERR_NONE;
        return r;
    endfunction

    function automatic result_t make_error(err_t code);
        result_t r;
        r.kind        = KIND_ERROR;
        r.stream_id   = 1'b0;
        r.packet_time = 32'd0;
        r.payload_len = 32'd0;
        r.data_byte   = 8'd0;
        r.last        = 1'b0;
        r.error_code  = code;
        return r;
    endfunction

endpackage

// ===== rtl/ccd_byte_if.sv =====
// Byte stream channel: one container byte per beat.
interface ccd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/ccd_result_if.sv =====
// Result channel: one header, payload byte or error per beat.
interface ccd_result_if;
    import ccd_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       kind;
    logic        stream_id;
    logic [31:0] packet_time;
    logic [31:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;
    err_t        error_code;

    modport source (output valid, output kind, output stream_id, output packet_time,
                    output payload_len, output data_byte, output last,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input stream_id, input packet_time,
                    input payload_len, input data_byte, input last,
                    input error_code, output ready);
endinterface

// ===== rtl/camera_container_deframer.sv =====
// Top level of the camera container deframer.
//
// Channels: raw takes the container stream one byte per beat; pkt gives one
// result per beat: a packet header (time, length), a payload byte, or an
// error. cfg_we/cfg_data write the 16-bit audio step in milliseconds.
// Throughput: one byte per clock while the result queue is not full. A
// result is written into the result queue as its byte is taken and then
// moves to the pkt output register when it is empty or being taken.
// Skipped bytes, bytes after an error and most header bytes give no result.
// The parser and the output stage are parted by a QUEUE_DEPTH-entry queue;
// raw.ready drops only while that queue is full, so a stalled receiver
// backs up the queue before it stops the stream.
// Reset clears the parser to expect a frame tag, drops any latched error,
// empties the queue and output register, and sets the audio step to 20 ms.
// After an error result every byte that is taken is dropped until reset.
module camera_container_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ccd_byte_if.sink    raw,
    ccd_result_if.source pkt,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);
    import ccd_pkg::*;

    logic [15:0] audio_step_reg;
    push_t       push;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    result_t     q_data;

    // Audio step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_step_reg <= AUDIO_STEP_RESET;
        end
        else if (cfg_we)
        begin
            audio_step_reg <= cfg_data;
        end
    end

    ccd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw        (raw),
        .audio_step (audio_step_reg),
        .q_full     (q_full),
        .push       (push)
    );

    ccd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (q_pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    ccd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (q_pop),
        .pkt     (pkt)
    );

    // The parser never writes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !q_full)
        else $error("result pushed into full queue");

    // The output stage only drains a queue that holds a record
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");

    // An error stops the parser from producing more results
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.rec.kind == KIND_ERROR) |=> !push.valid)
        else $error("result produced after error");

    // A packet's final payload byte is followed by a tag, never another payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.rec.kind == KIND_PAYLOAD && push.rec.last)
        |=> !(push.valid && push.rec.kind == KIND_PAYLOAD))
        else $error("payload byte directly after end of packet");

endmodule

// ===== rtl/ccd_front.sv =====
// Front end: accepts stream bytes, parses frames and builds result records.
module ccd_front (
    input  logic            clk,
    input  logic            rst_n,
    ccd_byte_if.sink        raw,
    input  logic [15:0]     audio_step,
    input  logic            q_full,
    output ccd_pkg::push_t  push
);
    import ccd_pkg::*;

    typedef enum logic [6:0] {
        PH_TAG     = 7'b000_0001,
        PH_SIZE    = 7'b000_0010,
        PH_TS      = 7'b000_0100,
        PH_SUB     = 7'b000_1000,
        PH_PREFIX  = 7'b001_0000,
        PH_PAYLOAD = 7'b010_0000,
        PH_SKIP    = 7'b100_0000
    } phase_t;

    typedef enum logic [1:0] {
        FK_VIDEO = 2'd0,
        FK_AUDIO = 2'd1,
        FK_INDEX = 2'd2
    } fkind_t;

    phase_t      phase_reg, phase_next;
    fkind_t      fkind_reg, fkind_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [23:0] shift_reg, shift_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] start_reg, start_next;
    logic        stv_reg, stv_next;
    logic [31:0] lvt_reg, lvt_next;
    logic [31:0] run_reg, run_next;
    logic [31:0] prod_reg, prod_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        sid;
    logic [31:0] word;
    logic [31:0] st_eff;
    logic [31:0] vid_time;
    logic [31:0] idx_skip;
    logic [31:0] aud_len;
    logic [31:0] aud_time;
    logic [47:0] prod_full;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && raw.ready;
    assign sid       = (fkind_reg == FK_AUDIO);

    // Datapath terms for the word that completes on this beat
    assign word      = {raw.in_byte, shift_reg};
    assign st_eff    = stv_reg ? start_reg : ts_reg;
    assign vid_time  = ts_reg - st_eff;
    assign idx_skip  = word + INDEX_EXTRA;
    assign aud_len   = rem_reg - PREFIX_LEN;
    assign aud_time  = lvt_reg + prod_reg;
    assign prod_full = audio_step * run_reg;

    // Parse one beat
    always_comb
    begin
        phase_next = phase_reg;
        fkind_next = fkind_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        ts_next    = ts_reg;
        start_next = start_reg;
        stv_next   = stv_reg;
        lvt_next   = lvt_reg;
        run_next   = run_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;
        push       = '0;

        if (accept && !err_reg)
        begin
            if (phase_reg == PH_PAYLOAD || phase_reg == PH_SKIP)
            begin
                // Count down the body; the last byte returns to tag parsing
                rem_next = rem_reg - 32'd1;
                if (rem_reg == 32'd1)
                begin
                    phase_next = PH_TAG;
                end
                if (phase_reg == PH_PAYLOAD)
                begin
                    push.valid = 1'b1;
                    push.rec   = make_payload(sid, raw.in_byte, rem_reg == 32'd1);
                end
            end
            else if (cnt_reg != 2'd3)
            begin
                // Collect low bytes of a little-endian word
                case (cnt_reg)
                    2'd0:    shift_next[7:0]   = raw.in_byte;
                    2'd1:    shift_next[15:8]  = raw.in_byte;
                    default: shift_next[23:16] = raw.in_byte;
                endcase
                cnt_next = cnt_reg + 2'd1;
            end
            else
            begin
                cnt_next = 2'd0;
                case (phase_reg)
                    PH_TAG:
                    begin
                        if (word == TAG_START)
                        begin
                            rem_next   = START_SKIP;
                            phase_next = PH_SKIP;
                        end
                        else if (word == TAG_VIDEO)
                        begin
                            fkind_next = FK_VIDEO;
                            phase_next = PH_SIZE;
                        end
                        else if (word == TAG_AUDIO)
                        begin
                            fkind_next = FK_AUDIO;
                            phase_next = PH_SIZE;
                        end
                        else if (word == TAG_INDEX)
                        begin
                            fkind_next = FK_INDEX;
                            phase_next = PH_SIZE;
                        end
                        else
                        begin
                            err_next   = 1'b1;
                            push.valid = 1'b1;
                            push.rec   = make_error(ERR_TAG);
                        end
                    end
                    PH_SIZE:
                    begin
                        if (fkind_reg == FK_INDEX)
                        begin
                            rem_next   = idx_skip;
                            phase_next = (idx_skip == 32'd0) ? PH_TAG : PH_SKIP;
                        end
                        else
                        begin
                            rem_next   = word;
                            phase_next = PH_TS;
                        end
                    end
                    PH_TS:
                    begin
                        ts_next    = word;
                        phase_next = PH_SUB;
                    end
                    PH_SUB:
                    begin
                        // Latch the first timestamp as the start time
                        if (!stv_reg)
                        begin
                            start_next = ts_reg;
                            stv_next   = 1'b1;
                        end
                        if (fkind_reg == FK_AUDIO)
                        begin
                            // Audio time is finished on the prefix word
                            prod_next  = prod_full[31:0];
                            run_next   = run_reg + 32'd1;
                            phase_next = PH_PREFIX;
                        end
                        else
                        begin
                            if (vid_time != lvt_reg)
                            begin
                                run_next = 32'd0;
                                lvt_next = vid_time;
                            end
                            phase_next = (rem_reg == 32'd0) ? PH_TAG : PH_PAYLOAD;
                            push.valid = 1'b1;
                            push.rec   = make_header(1'b0, vid_time, rem_reg);
                        end
                    end
                    PH_PREFIX:
                    begin
                        push.valid = 1'b1;
                        if (word != AUDIO_PREFIX)
                        begin
                            err_next = 1'b1;
                            push.rec = make_error(ERR_PREFIX);
                        end
                        else if (rem_reg < PREFIX_LEN)
                        begin
                            err_next = 1'b1;
                            push.rec = make_error(ERR_SHORT);
                        end
                        else
                        begin
                            rem_next   = aud_len;
                            phase_next = (aud_len == 32'd0) ? PH_TAG : PH_PAYLOAD;
                            push.rec   = make_header(1'b1, aud_time, aud_len);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TAG;
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            fkind_reg <= FK_VIDEO;
            cnt_reg   <= 2'd0;
            rem_reg   <= 32'd0;
            start_reg <= 32'd0;
            stv_reg   <= 1'b0;
            lvt_reg   <= 32'd0;
            run_reg   <= 32'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fkind_reg <= fkind_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            start_reg <= start_next;
            stv_reg   <= stv_next;
            lvt_reg   <= lvt_next;
            run_reg   <= run_next;
            err_reg   <= err_next;
        end
    end

    // Word bytes and timing terms
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        ts_reg    <= ts_next;
        prod_reg  <= prod_next;
    end

endmodule

// ===== rtl/ccd_queue.sv =====
// Result queue between the parser and the output stage.
module ccd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ccd_pkg::push_t   push,
    input  logic             pop,
    output logic             full,
    output logic             q_valid,
    output ccd_pkg::result_t q_data
);
    import ccd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t        entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.rec;
        end
    end

endmodule

// ===== rtl/ccd_back.sv =====
// Output stage: drains the result queue into a registered result channel.
module ccd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ccd_pkg::result_t q_data,
    output logic             pop,
    ccd_result_if.source     pkt
);
    import ccd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // Load a new beat when the register is empty or being taken
    assign pop = q_valid && (!out_valid_reg || pkt.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = q_data;
        end
        else if (pkt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Drive the channel from the output register
    assign pkt.valid       = out_valid_reg;
    assign pkt.kind        = out_data_reg.kind;
    assign pkt.stream_id   = out_data_reg.stream_id;
    assign pkt.packet_time = out_data_reg.packet_time;
    assign pkt.payload_len = out_data_reg.payload_len;
    assign pkt.data_byte   = out_data_reg.data_byte;
    assign pkt.last        = out_data_reg.last;
    assign pkt.error_code  = out_data_reg.error_code;

endmodule
